// ----- src/efsg_pkg.sv -----
// Shared types, constants and helpers of the encoder following stepper guard.
package efsg_pkg;

    localparam int POS_BITS   = 24;
    localparam int COUNT_BITS = 32;
    localparam int TIMER_BITS = 20;

    localparam int IN_FIELDS  = 6;
    localparam int IN_BYTES   = (IN_FIELDS + 7) / 8;
    localparam int IN_W       = 8 * IN_BYTES;
    localparam int OUT_FIELDS = 5 + 2 * POS_BITS;
    localparam int OUT_BYTES  = (OUT_FIELDS + 7) / 8;
    localparam int OUT_W      = 8 * OUT_BYTES;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [TIMER_BITS-1:0] t_tmr;
    typedef logic [2:0]            t_mode;
    typedef logic [1:0]            t_phase;
    typedef logic [2:0]            t_reg_idx;

    localparam t_mode M_HCLOSE  = 3'd0;
    localparam t_mode M_WAITH   = 3'd1;
    localparam t_mode M_HOPEN   = 3'd2;
    localparam t_mode M_IDLE    = 3'd3;
    localparam t_mode M_CLOSING = 3'd4;
    localparam t_mode M_OPENING = 3'd5;
    localparam t_mode M_HOLD    = 3'd6;
    localparam t_mode M_SWAIT   = 3'd7;

    localparam t_phase PH_SETTLE = 2'd0;
    localparam t_phase PH_HIGH   = 2'd1;
    localparam t_phase PH_LOW    = 2'd2;

    localparam t_reg_idx R_SETUP_DELAY = 3'd0;
    localparam t_reg_idx R_RUN_DELAY   = 3'd1;
    localparam t_reg_idx R_PULSE_WIDTH = 3'd2;
    localparam t_reg_idx R_CHECK_INT   = 3'd3;
    localparam t_reg_idx R_THRESHOLD   = 3'd4;
    localparam t_reg_idx R_DIR_SETTLE  = 3'd5;
    localparam t_reg_idx R_SW_SETTLE   = 3'd6;

    localparam logic [15:0] RST_SETUP_DELAY = 16'd400;
    localparam logic [15:0] RST_RUN_DELAY   = 16'd150;
    localparam logic [7:0]  RST_PULSE_WIDTH = 8'd10;
    localparam logic [19:0] RST_CHECK_INT   = 20'd10000;
    localparam logic [15:0] RST_THRESHOLD   = 16'd10;
    localparam logic [19:0] RST_DIR_SETTLE  = 20'd10000;
    localparam logic [19:0] RST_SW_SETTLE   = 20'd30000;

    function automatic t_tmr tinc(input t_tmr v);
        tinc = (v != '1) ? v + t_tmr'(1) : v;
    endfunction

endpackage

// ----- src/encoder_following_stepper_guard_top.sv -----
// Stepper guard controller: encoder decode, homing, interval checks and moves.
//
//  port group   dir   transfer when                   contents
//  s_axis_*     in    s_axis_tvalid & s_axis_tready   one sampled 1 us tick of pin levels
//  m_axis_*     out   m_axis_tvalid & m_axis_tready   step/dir, mode, position, stroke
//  apb (p*)     in    psel & penable & pwrite         register write, 4-byte stride
//
//  One item per clock sustained while the output is not stalled.
//  The input register feeds one pass of next-state logic into the result register.
//  Reset is synchronous, active low; the block accepts items right after it.
//  A stalled result holds the result register; the input register still takes one more.
module encoder_following_stepper_guard_top
    import efsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] closed_sensor [1] opened_sensor [2] handle_sensor [3] setup_switch
    // [4] enc_a [5] enc_b
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] step_out [1] dir_out [4:2] mode [28:5] position [52:29] stroke_length
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [CFG_DW-1:0]    pwdata,
    output logic [CFG_DW-1:0]    prdata,
    output logic                 pready
);

    logic [15:0]  r_setup_delay;
    logic [15:0]  r_run_delay;
    logic [7:0]   r_pulse_width;
    logic [19:0]  r_check_int;
    logic [15:0]  r_threshold;
    logic [19:0]  r_dir_settle;
    logic [19:0]  r_sw_settle;

    logic                   r_in_valid;
    logic [IN_FIELDS-1:0]   r_in;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out;

    t_mode   r_mode,  n_mode;
    t_cnt    r_cnt,   n_cnt;
    t_cnt    r_snap,  n_snap;
    logic [1:0] r_last_ab, n_last_ab;
    t_tmr    r_itimer, n_itimer;
    t_tmr    r_stimer, n_stimer;
    t_phase  r_phase, n_phase;
    t_pos    r_pos,   n_pos;
    t_pos    r_stroke, n_stroke;
    t_pos    r_scnt,  n_scnt;
    logic    n_step;
    logic    n_dir;

    logic       advance;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[CFG_AW-1:2];

    always_comb begin
        unique case (cfg_idx)
            R_SETUP_DELAY: prdata = CFG_DW'(r_setup_delay);
            R_RUN_DELAY:   prdata = CFG_DW'(r_run_delay);
            R_PULSE_WIDTH: prdata = CFG_DW'(r_pulse_width);
            R_CHECK_INT:   prdata = CFG_DW'(r_check_int);
            R_THRESHOLD:   prdata = CFG_DW'(r_threshold);
            R_DIR_SETTLE:  prdata = CFG_DW'(r_dir_settle);
            R_SW_SETTLE:   prdata = CFG_DW'(r_sw_settle);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_delay <= RST_SETUP_DELAY;
            r_run_delay   <= RST_RUN_DELAY;
            r_pulse_width <= RST_PULSE_WIDTH;
            r_check_int   <= RST_CHECK_INT;
            r_threshold   <= RST_THRESHOLD;
            r_dir_settle  <= RST_DIR_SETTLE;
            r_sw_settle   <= RST_SW_SETTLE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                R_SETUP_DELAY: r_setup_delay <= pwdata[15:0];
                R_RUN_DELAY:   r_run_delay   <= pwdata[15:0];
                R_PULSE_WIDTH: r_pulse_width <= pwdata[7:0];
                R_CHECK_INT:   r_check_int   <= pwdata[19:0];
                R_THRESHOLD:   r_threshold   <= pwdata[15:0];
                R_DIR_SETTLE:  r_dir_settle  <= pwdata[19:0];
                R_SW_SETTLE:   r_sw_settle   <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        logic closed_s, opened_s, handle, sw, enc_a, enc_b, sensor;
        logic [1:0] chg;
        t_tmr t, delay;
        t_cnt d;
        t_pos p;
        logic more, moved, done;

        closed_s = r_in[0];
        opened_s = r_in[1];
        handle   = r_in[2];
        sw       = r_in[3];
        enc_a    = r_in[4];
        enc_b    = r_in[5];
        sensor   = 1'b1;
        t        = '0;
        delay    = '0;
        d        = '0;
        p        = r_pos;
        more     = 1'b0;
        moved    = 1'b0;
        done     = 1'b0;

        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_snap   = r_snap;
        n_itimer = r_itimer;
        n_stimer = r_stimer;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_stroke = r_stroke;
        n_scnt   = r_scnt;

        // quadrature decode, simultaneous change of both ignored
        n_last_ab = {enc_a, enc_b};
        chg       = n_last_ab ^ r_last_ab;
        if (chg == 2'b10) begin
            n_cnt = (enc_a == enc_b) ? r_cnt + t_cnt'(1) : r_cnt - t_cnt'(1);
        end else if (chg == 2'b01) begin
            n_cnt = (enc_a != enc_b) ? r_cnt + t_cnt'(1) : r_cnt - t_cnt'(1);
        end

        unique case (r_mode)
            M_HCLOSE, M_HOPEN: begin
                sensor   = (r_mode == M_HCLOSE) ? closed_s : opened_s;
                t        = tinc(r_stimer);
                n_stimer = t;
                if (r_phase == PH_HIGH) begin
                    if (t >= t_tmr'(r_pulse_width)) begin
                        n_phase  = PH_LOW;
                        n_stimer = '0;
                        if (r_mode == M_HOPEN && r_scnt != '1) begin
                            n_scnt = r_scnt + t_pos'(1);
                        end
                    end
                end else begin
                    n_phase = PH_LOW;
                    if (!sensor) begin
                        done = 1'b1;
                    end else if (t >= t_tmr'(r_setup_delay)) begin
                        n_phase  = PH_HIGH;
                        n_stimer = '0;
                    end
                end
                if (done) begin
                    if (r_mode == M_HCLOSE) begin
                        n_mode = M_WAITH;
                    end else begin
                        n_stroke = r_scnt;
                        n_pos    = '0;
                        n_mode   = M_IDLE;
                        n_snap   = n_cnt;
                        n_itimer = '0;
                        n_phase  = PH_SETTLE;
                        n_stimer = '0;
                    end
                end
            end
            M_WAITH: begin
                n_stimer = tinc(r_stimer);
                if (!handle) begin
                    n_mode = M_HOPEN;
                    n_scnt = '0;
                end
            end
            M_IDLE: begin
                if (sw) begin
                    n_mode   = M_SWAIT;
                    n_stimer = '0;
                end else begin
                    n_itimer = tinc(r_itimer);
                    if (n_itimer >= t_tmr'(r_check_int)) begin
                        d = n_cnt - r_snap;
                        if (!d[COUNT_BITS-1]) begin
                            if (d > t_cnt'(r_threshold)) begin
                                n_mode = M_CLOSING;
                                moved  = 1'b1;
                            end
                        end else if ((t_cnt'(0) - d) > t_cnt'(r_threshold)) begin
                            n_mode = M_OPENING;
                            moved  = 1'b1;
                        end
                        if (moved) begin
                            n_phase  = PH_SETTLE;
                            n_stimer = '0;
                        end else begin
                            n_snap   = n_cnt;
                            n_itimer = '0;
                        end
                    end
                    if (!moved && handle) begin
                        n_mode   = M_HOLD;
                        n_phase  = PH_SETTLE;
                        n_stimer = '0;
                    end
                end
            end
            M_CLOSING, M_OPENING, M_HOLD: begin
                delay    = (r_mode == M_HOLD) ? t_tmr'(r_setup_delay) : t_tmr'(r_run_delay);
                t        = tinc(r_stimer);
                n_stimer = t;
                unique case (r_phase)
                    PH_HIGH: begin
                        if (t >= t_tmr'(r_pulse_width)) begin
                            n_phase  = PH_LOW;
                            n_stimer = '0;
                        end
                    end
                    PH_LOW: begin
                        if (t >= delay) begin
                            p     = (r_mode == M_OPENING) ? r_pos - t_pos'(1)
                                                          : r_pos + t_pos'(1);
                            n_pos = p;
                            done  = 1'b1;
                        end
                    end
                    default: begin
                        if (t >= t_tmr'(r_dir_settle)) begin
                            done = 1'b1;
                        end
                    end
                endcase
                if (done) begin
                    more = (r_mode == M_OPENING) ? (p != '0) : (p < r_stroke);
                    if (more) begin
                        n_phase  = PH_HIGH;
                        n_stimer = '0;
                    end else if (r_mode != M_HOLD) begin
                        n_mode   = M_IDLE;
                        n_snap   = n_cnt;
                        n_itimer = '0;
                        n_phase  = PH_SETTLE;
                        n_stimer = '0;
                    end else if (!handle) begin
                        n_mode   = M_HCLOSE;
                        n_phase  = PH_LOW;
                        n_stimer = '0;
                    end else begin
                        n_phase  = PH_SETTLE;
                        n_stimer = '0;
                    end
                end
            end
            default: begin
                n_stimer = sw ? '0 : tinc(r_stimer);
                if (!sw && n_stimer >= t_tmr'(r_sw_settle)) begin
                    n_mode   = M_HCLOSE;
                    n_phase  = PH_LOW;
                    n_stimer = '0;
                end
            end
        endcase

        n_step = (n_phase == PH_HIGH) && (n_mode != M_IDLE) && (n_mode != M_WAITH)
                 && (n_mode != M_SWAIT);
        n_dir  = (n_mode == M_HOPEN) || (n_mode == M_OPENING);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= M_HCLOSE;
            r_cnt       <= '0;
            r_snap      <= '0;
            r_last_ab   <= '0;
            r_itimer    <= '0;
            r_stimer    <= '0;
            r_phase     <= PH_SETTLE;
            r_pos       <= '0;
            r_stroke    <= '0;
            r_scnt      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_cnt       <= n_cnt;
                r_snap      <= n_snap;
                r_last_ab   <= n_last_ab;
                r_itimer    <= n_itimer;
                r_stimer    <= n_stimer;
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_stroke    <= n_stroke;
                r_scnt      <= n_scnt;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[IN_FIELDS-1:0];
        end
        if (advance) begin
            r_out <= OUT_W'({n_stroke, n_pos, n_mode, n_dir, n_step});
        end
    end

endmodule

// ----- src/efsg_checker.sv -----
// Port-level assertions for the stepper guard controller, bound to its top level.
module efsg_port_props
    import efsg_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    t_mode out_mode;
    assign out_mode = m_axis_tdata[4:2];

    a_stall_only_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_no_step_when_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (out_mode == M_IDLE || out_mode == M_WAITH
                           || out_mode == M_SWAIT)) |-> !m_axis_tdata[0])
        else $error("step pulse in a parked mode");

    a_dir_follows_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1] == (out_mode == M_HOPEN || out_mode == M_OPENING)))
        else $error("direction does not match mode");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind encoder_following_stepper_guard_top efsg_port_props u_efsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/efsg_checker.sv -----
`timescale 1ns / 100ps
// Checker for the guard controller: watches the stream ports and register writes, predicts each result and compares it.
module efsg_checker
    import efsg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [OUT_W-1:0]  i_m_tdata,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results
);

    typedef struct packed {
        logic  step;
        logic  dir;
        t_mode mode;
        t_pos  pos;
        t_pos  stroke;
    } t_guard_out;

    t_guard_out guard_out_q[$];

    int fails   = 0;
    int checked = 0;

    logic [15:0] cfg_setup_dly, cfg_run_dly, cfg_thresh;
    logic [7:0]  cfg_pulse;
    t_tmr        cfg_check, cfg_dir_settle, cfg_sw_settle;

    t_mode      guard_mode;
    t_cnt       enc_cnt, enc_snap;
    logic [1:0] prev_ab;
    t_tmr       intv_tmr, step_tmr;
    t_phase     step_ph;
    t_pos       pos_q, stroke_q, homing_steps;

    function automatic t_tmr sat_inc(input t_tmr v);
        return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    task automatic enter_idle();
        guard_mode = M_IDLE;
        enc_snap   = enc_cnt;
        intv_tmr   = '0;
        step_ph    = PH_SETTLE;
        step_tmr   = '0;
    endtask

    task automatic begin_homing();
        guard_mode = M_HCLOSE;
        step_ph    = PH_LOW;
        step_tmr   = '0;
    endtask

    task automatic begin_move(input t_mode m);
        guard_mode = m;
        step_ph    = PH_SETTLE;
        step_tmr   = '0;
    endtask

    task automatic next_step_or_finish(input logic handle);
        logic more;
        more = (guard_mode == M_OPENING) ? (pos_q != '0) : (pos_q < stroke_q);
        if (more) begin
            step_ph  = PH_HIGH;
            step_tmr = '0;
        end else if (guard_mode != M_HOLD) begin
            enter_idle();
        end else if (!handle) begin
            begin_homing();
        end else begin
            step_ph  = PH_SETTLE;
            step_tmr = '0;
        end
    endtask

    task automatic advance_move(input logic [15:0] dly, input logic handle);
        step_tmr = sat_inc(step_tmr);
        case (step_ph)
            PH_HIGH: begin
                if (step_tmr >= cfg_pulse) begin
                    step_ph  = PH_LOW;
                    step_tmr = '0;
                end
            end
            PH_LOW: begin
                if (step_tmr >= dly) begin
                    pos_q = (guard_mode == M_OPENING) ? pos_q - 1'b1 : pos_q + 1'b1;
                    next_step_or_finish(handle);
                end
            end
            default: begin
                if (step_tmr >= cfg_dir_settle) next_step_or_finish(handle);
            end
        endcase
    endtask

    task automatic homing_tick(input logic sensor, output logic reached);
        reached  = 1'b0;
        step_tmr = sat_inc(step_tmr);
        if (step_ph == PH_HIGH) begin
            if (step_tmr >= cfg_pulse) begin
                step_ph  = PH_LOW;
                step_tmr = '0;
                if (guard_mode == M_HOPEN && homing_steps != '1)
                    homing_steps = homing_steps + 1'b1;
            end
        end else begin
            step_ph = PH_LOW;
            if (!sensor) begin
                reached = 1'b1;
            end else if (step_tmr >= cfg_setup_dly) begin
                step_ph  = PH_HIGH;
                step_tmr = '0;
            end
        end
    endtask

    task automatic predict_tick(input logic [IN_W-1:0] d, output t_guard_out r);
        logic       closed, opened, handle, sw, a, b, moved, reached;
        logic [1:0] ab, chg;
        t_cnt       diff, neg;
        closed = d[0];
        opened = d[1];
        handle = d[2];
        sw     = d[3];
        a      = d[4];
        b      = d[5];
        ab     = {a, b};
        chg    = ab ^ prev_ab;
        if (chg == 2'b10)
            enc_cnt = (a == b) ? enc_cnt + 1'b1 : enc_cnt - 1'b1;
        else if (chg == 2'b01)
            enc_cnt = (a != b) ? enc_cnt + 1'b1 : enc_cnt - 1'b1;
        prev_ab = ab;

        case (guard_mode)
            M_HCLOSE: begin
                homing_tick(closed, reached);
                if (reached) guard_mode = M_WAITH;
            end
            M_WAITH: begin
                step_tmr = sat_inc(step_tmr);
                if (!handle) begin
                    guard_mode   = M_HOPEN;
                    homing_steps = '0;
                end
            end
            M_HOPEN: begin
                homing_tick(opened, reached);
                if (reached) begin
                    stroke_q = homing_steps;
                    pos_q    = '0;
                    enter_idle();
                end
            end
            M_IDLE: begin
                moved = 1'b0;
                if (sw) begin
                    guard_mode = M_SWAIT;
                    step_tmr   = '0;
                end else begin
                    intv_tmr = sat_inc(intv_tmr);
                    if (intv_tmr >= cfg_check) begin
                        diff = enc_cnt - enc_snap;
                        neg  = '0 - diff;
                        if (!diff[COUNT_BITS-1]) begin
                            if (diff > cfg_thresh) begin
                                begin_move(M_CLOSING);
                                moved = 1'b1;
                            end
                        end else if (neg > cfg_thresh) begin
                            begin_move(M_OPENING);
                            moved = 1'b1;
                        end
                        if (!moved) begin
                            enc_snap = enc_cnt;
                            intv_tmr = '0;
                        end
                    end
                    if (!moved && handle) begin_move(M_HOLD);
                end
            end
            M_CLOSING, M_OPENING: advance_move(cfg_run_dly, handle);
            M_HOLD:               advance_move(cfg_setup_dly, handle);
            default: begin
                step_tmr = sw ? t_tmr'(0) : sat_inc(step_tmr);
                if (!sw && step_tmr >= cfg_sw_settle) begin_homing();
            end
        endcase

        r.step   = (step_ph == PH_HIGH) && (guard_mode != M_IDLE) &&
                   (guard_mode != M_WAITH) && (guard_mode != M_SWAIT);
        r.dir    = (guard_mode == M_HOPEN) || (guard_mode == M_OPENING);
        r.mode   = guard_mode;
        r.pos    = pos_q;
        r.stroke = stroke_q;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_guard_out want, got;
        if (!i_rst_n) begin
            cfg_setup_dly  = RST_SETUP_DELAY;
            cfg_run_dly    = RST_RUN_DELAY;
            cfg_pulse      = RST_PULSE_WIDTH;
            cfg_check      = RST_CHECK_INT;
            cfg_thresh     = RST_THRESHOLD;
            cfg_dir_settle = RST_DIR_SETTLE;
            cfg_sw_settle  = RST_SW_SETTLE;
            guard_mode     = M_HCLOSE;
            enc_cnt        = '0;
            enc_snap       = '0;
            prev_ab        = '0;
            intv_tmr       = '0;
            step_tmr       = '0;
            step_ph        = PH_SETTLE;
            pos_q          = '0;
            stroke_q       = '0;
            homing_steps   = '0;
            guard_out_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_AW-1:2]))
                    R_SETUP_DELAY: cfg_setup_dly  = i_pwdata[15:0];
                    R_RUN_DELAY:   cfg_run_dly    = i_pwdata[15:0];
                    R_PULSE_WIDTH: cfg_pulse      = i_pwdata[7:0];
                    R_CHECK_INT:   cfg_check      = i_pwdata[TIMER_BITS-1:0];
                    R_THRESHOLD:   cfg_thresh     = i_pwdata[15:0];
                    R_DIR_SETTLE:  cfg_dir_settle = i_pwdata[TIMER_BITS-1:0];
                    R_SW_SETTLE:   cfg_sw_settle  = i_pwdata[TIMER_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.step   = i_m_tdata[0];
                got.dir    = i_m_tdata[1];
                got.mode   = i_m_tdata[4:2];
                got.pos    = i_m_tdata[5 +: POS_BITS];
                got.stroke = i_m_tdata[5 + POS_BITS +: POS_BITS];
                checked++;
                if (guard_out_q.size() == 0) begin
                    $display("%0t ns: result with nothing expected, expected none actual %h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want = guard_out_q.pop_front();
                    check_field("step_out", want.step, got.step);
                    check_field("dir_out", want.dir, got.dir);
                    check_field("mode", want.mode, got.mode);
                    check_field("position", want.pos, got.pos);
                    check_field("stroke_length", want.stroke, got.stroke);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_tick(i_s_tdata, want);
                guard_out_q.push_back(want);
            end
        end
        o_pending    <= guard_out_q.size();
        o_fail_count <= fails;
        o_results    <= checked;
    end

endmodule

// ----- tb/tb_encoder_following_stepper_guard_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the guard controller: ticks, register writes, back-pressure and verdict.
module tb_encoder_following_stepper_guard_top;
    import efsg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;

    localparam int SET_TIGHT = 0;
    localparam int SET_WIDE  = 1;
    localparam int SET_MIN   = 2;
    localparam int SET_MAX   = 3;
    localparam int SET_RAW   = 4;

    // b a switch handle opened closed, first tick in the highest bits
    localparam logic [24*6-1:0] DIRECTED = {
        6'b000111, 6'b000111, 6'b000110, 6'b000110, 6'b000010, 6'b000011,
        6'b000011, 6'b000011, 6'b000011, 6'b000001, 6'b100001, 6'b100001,
        6'b100001, 6'b100001, 6'b010001, 6'b010101, 6'b010111, 6'b010011,
        6'b011011, 6'b011011, 6'b000001, 6'b111111, 6'b000000, 6'b110001
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [CFG_AW-1:0] paddr         = '0;
    logic [CFG_DW-1:0] pwdata        = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int results;

    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    logic rx_idles  = 1'b1;
    int   hold_left    = 0;
    int   gap_left     = 0;
    int   stretch_left = 0;
    int   cycles       = 0;

    logic       lv_closed  = 1'b1;
    logic       lv_opened  = 1'b1;
    logic       lv_handle  = 1'b0;
    logic       lv_switch  = 1'b0;
    logic [1:0] enc_pos    = 2'd0;
    int         enc_dir    = 0;
    int         run_closed = 0;
    int         run_opened = 0;
    int         run_handle = 0;
    int         run_switch = 0;
    int         run_enc    = 0;
    logic       tx_idles   = 1'b1;
    int         tx_stretch = 0;
    int         ticks_sent = 0;
    int         settings_used = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    encoder_following_stepper_guard_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    efsg_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL encoder_following_stepper_guard_top");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD - 1;
            hold_done     <= 1'b1;
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
        end else begin
            if (stretch_left == 0) begin
                rx_idles     <= ($urandom_range(0, 2) != 0);
                stretch_left <= $urandom_range(16, 120);
            end else begin
                stretch_left <= stretch_left - 1;
            end
            if (!calm && rx_idles && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                gap_left      <= $urandom_range(0, 15);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [5:0] next_tick();
        logic [1:0] ab;
        if ($urandom_range(0, 99) < 12)
            return 6'($urandom_range(0, 63));
        if (run_closed == 0) begin
            lv_closed  = !lv_closed;
            run_closed = lv_closed ? $urandom_range(4, 40) : $urandom_range(1, 10);
        end else begin
            run_closed--;
        end
        if (run_opened == 0) begin
            lv_opened  = !lv_opened;
            run_opened = lv_opened ? $urandom_range(10, 80) : $urandom_range(1, 10);
        end else begin
            run_opened--;
        end
        if (run_handle == 0) begin
            lv_handle  = !lv_handle;
            run_handle = lv_handle ? $urandom_range(1, 30) : $urandom_range(50, 400);
        end else begin
            run_handle--;
        end
        if (run_switch == 0) begin
            lv_switch  = !lv_switch;
            run_switch = lv_switch ? $urandom_range(1, 8) : $urandom_range(100, 600);
        end else begin
            run_switch--;
        end
        if (run_enc == 0) begin
            enc_dir = $urandom_range(0, 2);
            run_enc = $urandom_range(8, 60);
        end else begin
            run_enc--;
        end
        if ($urandom_range(0, 1) == 1) begin
            if (enc_dir == 1) enc_pos = enc_pos + 2'd1;
            else if (enc_dir == 2) enc_pos = enc_pos - 2'd1;
        end
        if ($urandom_range(0, 39) == 0)
            enc_pos = enc_pos + 2'd2;
        ab = enc_pos ^ {1'b0, enc_pos[1]};
        return {ab[0], ab[1], lv_switch, lv_handle, lv_opened, lv_closed};
    endfunction

    task automatic send_tick(input logic [5:0] lv);
        if (tx_stretch == 0) begin
            tx_idles   = ($urandom_range(0, 2) != 0);
            tx_stretch = $urandom_range(10, 80);
        end else begin
            tx_stretch--;
        end
        if (!calm && tx_idles && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-6){1'b0}}, lv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic configure(input int kind);
        logic [CFG_DW-1:0] vals [7];
        case (kind)
            SET_TIGHT: begin
                vals[R_SETUP_DELAY] = $urandom_range(1, 4);
                vals[R_RUN_DELAY]   = $urandom_range(1, 4);
                vals[R_PULSE_WIDTH] = $urandom_range(1, 3);
                vals[R_CHECK_INT]   = $urandom_range(1, 30);
                vals[R_THRESHOLD]   = $urandom_range(0, 4);
                vals[R_DIR_SETTLE]  = $urandom_range(0, 6);
                vals[R_SW_SETTLE]   = $urandom_range(0, 12);
            end
            SET_WIDE: begin
                vals[R_SETUP_DELAY] = $urandom_range(1, 24);
                vals[R_RUN_DELAY]   = $urandom_range(1, 12);
                vals[R_PULSE_WIDTH] = $urandom_range(1, 12);
                vals[R_CHECK_INT]   = $urandom_range(8, 90);
                vals[R_THRESHOLD]   = $urandom_range(0, 12);
                vals[R_DIR_SETTLE]  = $urandom_range(0, 30);
                vals[R_SW_SETTLE]   = $urandom_range(0, 60);
            end
            SET_MIN: begin
                vals[R_SETUP_DELAY] = 1;
                vals[R_RUN_DELAY]   = 1;
                vals[R_PULSE_WIDTH] = 1;
                vals[R_CHECK_INT]   = 1;
                vals[R_THRESHOLD]   = 0;
                vals[R_DIR_SETTLE]  = 0;
                vals[R_SW_SETTLE]   = 0;
            end
            SET_MAX: begin
                vals[R_SETUP_DELAY] = 32'h0000_FFFF;
                vals[R_RUN_DELAY]   = 32'h0000_FFFF;
                vals[R_PULSE_WIDTH] = 32'h0000_00FF;
                vals[R_CHECK_INT]   = 32'h000F_FFFF;
                vals[R_THRESHOLD]   = 32'h0000_FFFF;
                vals[R_DIR_SETTLE]  = 32'h000F_FFFF;
                vals[R_SW_SETTLE]   = 32'h000F_FFFF;
            end
            default: begin
                for (int r = 0; r < 7; r++) vals[r] = $urandom();
            end
        endcase
        for (int r = 0; r < 7; r++) write_reg(t_reg_idx'(r), vals[r]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int kind, input int count, input logic with_hold);
        drain();
        configure(kind);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == 30) hold_req <= 1'b1;
            send_tick(next_tick());
        end
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        repeat (3) send_tick(6'b000111);
        drain();
        configure(SET_MIN);
        for (int i = 0; i < 24; i++) send_tick(DIRECTED[(23 - i) * 6 +: 6]);
        run_phase(SET_TIGHT, 110, 1'b1);
        run_phase(SET_WIDE, 110, 1'b0);
        run_phase(SET_MAX, 30, 1'b0);
        run_phase(SET_TIGHT, 110, 1'b0);
        run_phase(SET_RAW, 30, 1'b0);
        run_phase(SET_WIDE, 110, 1'b0);
        run_phase(SET_TIGHT, 110, 1'b0);
        run_phase(SET_MIN, 80, 1'b0);
        calm <= 1'b1;
        run_phase(SET_TIGHT, 120, 1'b0);
        drain();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_used, results);
        $display("Settings spanned minimum, maximum and raw 32-bit writes; one %0d-cycle stall",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("PASS encoder_following_stepper_guard_top");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL encoder_following_stepper_guard_top");
        end
        $finish;
    end

endmodule
